/* sv/xdiv_pkg.sv */
package xdiv_pkg;

    localparam logic [1:0] CMD_DIV8   = 2'd0;
    localparam logic [1:0] CMD_DIV16  = 2'd1;
    localparam logic [1:0] CMD_IDIV8  = 2'd2;
    localparam logic [1:0] CMD_IDIV16 = 2'd3;

    localparam int unsigned QBITS = 32;

    localparam logic [31:0] LIM_U8     = 32'd255;
    localparam logic [31:0] LIM_U16    = 32'd65535;
    localparam logic [31:0] LIM_S8_POS = 32'd127;
    localparam logic [31:0] LIM_S8_NEG = 32'd128;
    localparam logic [31:0] LIM_S16_POS = 32'd32767;
    localparam logic [31:0] LIM_S16_NEG = 32'd32768;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] dividend_high;
        logic [15:0] dividend_low;
        logic [15:0] divisor;
    } div_in_t;

    typedef struct packed {
        logic [15:0] quotient;
        logic [15:0] remainder;
        logic        divide_error;
    } div_out_t;

endpackage

/* sv/x86_div_idiv_unit.sv */
// Pipelined DIV/IDIV divider. Takes one division per cycle while the input is
// not stalled and returns each result through a register stage that takes
// operand magnitudes, 32 restoring stages that each produce one quotient bit,
// and a result register for the range check and sign fix-up. A stall on
// the result side only holds the stages that are occupied, so empty stages
// keep filling and the input stalls only once every stage holds an item.
module x86_div_idiv_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  xdiv_pkg::div_in_t cmd_data,
    output logic              res_valid,
    input  logic              res_stall,
    output xdiv_pkg::div_out_t res_data
);
    import xdiv_pkg::*;

    localparam int unsigned NSTG = QBITS + 1;

    typedef struct packed {
        logic        wide;
        logic        sgn;
        logic        n_neg;
        logic        q_neg;
        logic [15:0] rem;
        logic [31:0] nq;
        logic [15:0] den;
    } stage_t;

    stage_t     stg_reg   [NSTG];
    stage_t     stg_next  [NSTG];
    logic       vld_reg   [NSTG];
    logic       load      [NSTG + 1];
    div_out_t   res_data_reg;
    div_out_t   res_data_next;
    logic       res_valid_reg;

    // operand preparation
    logic        in_wide;
    logic        in_sgn;
    logic [31:0] n_raw;
    logic        n_neg;
    logic        d_neg;
    logic [15:0] lo_neg;
    logic [7:0]  dv8_neg;

    always_comb
    begin
        in_wide = cmd_data.command inside {CMD_DIV16, CMD_IDIV16};
        in_sgn  = cmd_data.command inside {CMD_IDIV8, CMD_IDIV16};
        n_raw   = in_wide ? {cmd_data.dividend_high, cmd_data.dividend_low}
                          : {16'd0, cmd_data.dividend_low};
        n_neg   = in_sgn & (in_wide ? cmd_data.dividend_high[15] : cmd_data.dividend_low[15]);
        d_neg   = in_sgn & (in_wide ? cmd_data.divisor[15] : cmd_data.divisor[7]);
        lo_neg  = 16'd0 - cmd_data.dividend_low;
        dv8_neg = 8'd0 - cmd_data.divisor[7:0];

        stg_next[0].wide  = in_wide;
        stg_next[0].sgn   = in_sgn;
        stg_next[0].n_neg = n_neg;
        stg_next[0].q_neg = n_neg ^ d_neg;
        stg_next[0].rem   = '0;
        if (!n_neg)
        begin
            stg_next[0].nq = n_raw;
        end
        else if (in_wide)
        begin
            stg_next[0].nq = 32'd0 - n_raw;
        end
        else
        begin
            stg_next[0].nq = {16'd0, lo_neg};
        end
        if (!d_neg)
        begin
            stg_next[0].den = in_wide ? cmd_data.divisor : {8'd0, cmd_data.divisor[7:0]};
        end
        else if (in_wide)
        begin
            stg_next[0].den = 16'd0 - cmd_data.divisor;
        end
        else
        begin
            stg_next[0].den = {8'd0, dv8_neg};
        end
    end

    // one quotient bit per stage
    genvar gi;
    generate
        for (gi = 1; gi < NSTG; gi++)
        begin : g_step
            logic [16:0] shifted;
            logic [16:0] diff;
            always_comb
            begin
                shifted = {stg_reg[gi-1].rem, stg_reg[gi-1].nq[31]};
                diff    = shifted - {1'b0, stg_reg[gi-1].den};
                stg_next[gi] = stg_reg[gi-1];
                if (shifted >= {1'b0, stg_reg[gi-1].den})
                begin
                    stg_next[gi].rem = diff[15:0];
                    stg_next[gi].nq  = {stg_reg[gi-1].nq[30:0], 1'b1};
                end
                else
                begin
                    stg_next[gi].rem = shifted[15:0];
                    stg_next[gi].nq  = {stg_reg[gi-1].nq[30:0], 1'b0};
                end
            end
        end
    endgenerate

    // range check and sign fix-up
    logic [31:0] q_mag;
    logic [31:0] limit;
    logic        err;
    logic [15:0] q_fix;
    logic [15:0] r_fix;

    always_comb
    begin
        q_mag = stg_reg[NSTG-1].nq;
        if (stg_reg[NSTG-1].sgn && stg_reg[NSTG-1].q_neg)
        begin
            limit = stg_reg[NSTG-1].wide ? LIM_S16_NEG : LIM_S8_NEG;
        end
        else if (stg_reg[NSTG-1].sgn)
        begin
            limit = stg_reg[NSTG-1].wide ? LIM_S16_POS : LIM_S8_POS;
        end
        else
        begin
            limit = stg_reg[NSTG-1].wide ? LIM_U16 : LIM_U8;
        end
        err   = q_mag > limit;
        q_fix = (stg_reg[NSTG-1].sgn && stg_reg[NSTG-1].q_neg) ? 16'd0 - q_mag[15:0]
                                                                : q_mag[15:0];
        r_fix = (stg_reg[NSTG-1].sgn && stg_reg[NSTG-1].n_neg) ? 16'd0 - stg_reg[NSTG-1].rem
                                                                : stg_reg[NSTG-1].rem;
        if (!stg_reg[NSTG-1].wide)
        begin
            q_fix = {8'd0, q_fix[7:0]};
            r_fix = {8'd0, r_fix[7:0]};
        end
        res_data_next.divide_error = err;
        res_data_next.quotient     = err ? 16'd0 : q_fix;
        res_data_next.remainder    = err ? 16'd0 : r_fix;
    end

    // a stage takes new content when it is empty or its item moves on
    always_comb
    begin
        load[NSTG] = !res_valid_reg || !res_stall;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load[0])
            begin
                vld_reg[0] <= cmd_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (load[NSTG])
            begin
                res_valid_reg <= vld_reg[NSTG-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            if (load[i])
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (load[NSTG])
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign cmd_stall = !load[0];
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // input blocks only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("input stalled while output side can move");

    // a transfer in lands in the first stage
    a_transfer_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> vld_reg[0])
        else $error("input transfer lost");

    // faulting divisions report zero results
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.divide_error |->
            res_data.quotient == 16'd0 && res_data.remainder == 16'd0)
        else $error("divide error with nonzero results");

    // 8-bit results are zero-extended
    a_byte_ext: assert property (@(posedge clk) disable iff (!rst_n)
        load[NSTG] && vld_reg[NSTG-1] && !stg_reg[NSTG-1].wide |=>
            res_data.quotient[15:8] == 8'd0 && res_data.remainder[15:8] == 8'd0)
        else $error("byte result not zero-extended");

endmodule

/* bench/tb_x86_div_idiv_unit.sv */
`timescale 1ns / 1ps

module tb_x86_div_idiv_unit;

    import xdiv_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [1:0] OPS [4] = '{CMD_DIV8, CMD_DIV16, CMD_IDIV8, CMD_IDIV16};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    div_in_t   cmd_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    div_out_t  res_data;

    div_in_t   pending_divisions[$];
    div_out_t  expected_results[$];

    int        in_idle_pct = 0;
    int        out_idle_pct = 0;
    int        hold_requests = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        idle_cycles = 0;
    int        sent_count = 0;
    int        checked_count = 0;
    int        fault_count = 0;
    int        error_count = 0;

    x86_div_idiv_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic div_out_t predict_division(input div_in_t c);
        logic        wide;
        logic        sgn;
        logic        n_neg;
        logic        d_neg;
        logic        q_neg;
        logic        fault;
        logic [31:0] n;
        logic [31:0] d;
        logic [31:0] q;
        logic [31:0] r;
        logic [31:0] lim_pos;
        logic [31:0] lim_neg;
        logic [15:0] omask;
        div_out_t    o;
        wide  = c.command[0];
        sgn   = c.command[1];
        n_neg = 1'b0;
        d_neg = 1'b0;
        q     = '0;
        r     = '0;
        if (wide)
        begin
            n       = {c.dividend_high, c.dividend_low};
            d       = {16'h0000, c.divisor};
            lim_pos = sgn ? LIM_S16_POS : LIM_U16;
            lim_neg = LIM_S16_NEG;
            omask   = 16'hffff;
            if (sgn)
            begin
                n_neg = n[31];
                d_neg = d[15];
                if (n_neg)
                    n = 32'd0 - n;
                if (d_neg)
                    d = (32'd0 - d) & 32'h0000_ffff;
            end
        end
        else
        begin
            n       = {16'h0000, c.dividend_low};
            d       = {24'h000000, c.divisor[7:0]};
            lim_pos = sgn ? LIM_S8_POS : LIM_U8;
            lim_neg = LIM_S8_NEG;
            omask   = 16'h00ff;
            if (sgn)
            begin
                n_neg = n[15];
                d_neg = d[7];
                if (n_neg)
                    n = (32'd0 - n) & 32'h0000_ffff;
                if (d_neg)
                    d = (32'd0 - d) & 32'h0000_00ff;
            end
        end
        q_neg = n_neg ^ d_neg;
        if (d == 0)
            fault = 1'b1;
        else
        begin
            q = n / d;
            r = n % d;
            fault = (sgn && q_neg) ? (q > lim_neg) : (q > lim_pos);
        end
        if (fault)
        begin
            o.quotient     = '0;
            o.remainder    = '0;
            o.divide_error = 1'b1;
        end
        else
        begin
            if (sgn && q_neg)
                q = 32'd0 - q;
            if (sgn && n_neg)
                r = 32'd0 - r;
            o.quotient     = q[15:0] & omask;
            o.remainder    = r[15:0] & omask;
            o.divide_error = 1'b0;
        end
        return o;
    endfunction

    // quotient and remainder chosen first so most items stay in range
    function automatic div_in_t fitting_division();
        div_in_t     c;
        logic [1:0]  op;
        logic        wide;
        logic        sgn;
        logic        n_neg;
        logic        d_neg;
        logic [31:0] qm;
        logic [31:0] dm;
        logic [31:0] rm;
        logic [31:0] n;
        logic [31:0] d;
        logic [31:0] dmax;
        logic [31:0] qmax;
        logic [31:0] noise;
        op    = OPS[2'($urandom_range(0, 3))];
        wide  = op[0];
        sgn   = op[1];
        n_neg = sgn & 1'($urandom_range(0, 1));
        d_neg = sgn & 1'($urandom_range(0, 1));
        if (wide)
        begin
            dmax = sgn ? (d_neg ? LIM_S16_NEG : LIM_S16_POS) : LIM_U16;
            qmax = sgn ? ((n_neg ^ d_neg) ? LIM_S16_NEG : LIM_S16_POS) : LIM_U16;
        end
        else
        begin
            dmax = sgn ? (d_neg ? LIM_S8_NEG : LIM_S8_POS) : LIM_U8;
            qmax = sgn ? ((n_neg ^ d_neg) ? LIM_S8_NEG : LIM_S8_POS) : LIM_U8;
        end
        dm = $urandom_range(1, dmax) >> $urandom_range(0, wide ? 15 : 7);
        if (dm == 0)
            dm = 1;
        if ($urandom_range(0, 9) == 0)
            dm = dmax;
        qm = $urandom_range(0, qmax) >> $urandom_range(0, wide ? 15 : 7);
        if ($urandom_range(0, 7) == 0)
            qm = qmax;
        rm = $urandom_range(0, dm - 1);
        n  = qm * dm + rm;
        if (n_neg)
            n = 32'd0 - n;
        d  = d_neg ? 32'd0 - dm : dm;
        noise = $urandom;
        c.command = op;
        if (wide)
        begin
            c.dividend_high = n[31:16];
            c.dividend_low  = n[15:0];
            c.divisor       = d[15:0];
        end
        else
        begin
            c.dividend_high = noise[31:16];
            c.dividend_low  = n[15:0];
            c.divisor       = {noise[7:0], d[7:0]};
        end
        return c;
    endfunction

    function automatic div_in_t noisy_division();
        div_in_t     c;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        c.command       = OPS[2'($urandom_range(0, 3))];
        c.dividend_high = a[31:16];
        c.dividend_low  = a[15:0];
        c.divisor       = b[15:0] >> $urandom_range(0, 15);
        case ($urandom_range(0, 5))
            0: c.divisor = 16'h0000;
            1: c.divisor = 16'hffff;
            2: c.divisor = {b[31:24], 8'h00};
            3: c.divisor = {b[31:24], 8'hff};
            4: c.divisor = 16'h8000;
            default: ;
        endcase
        return c;
    endfunction

    task automatic add_division(input logic [1:0] op, input logic [15:0] hi,
                                input logic [15:0] lo, input logic [15:0] dv);
        div_in_t c;
        c.command       = op;
        c.dividend_high = hi;
        c.dividend_low  = lo;
        c.divisor       = dv;
        pending_divisions.push_back(c);
    endtask

    task automatic add_random_divisions(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pending_divisions.push_back(fitting_division());
            else
                pending_divisions.push_back(noisy_division());
        end
    endtask

    task automatic wait_drained();
        while (pending_divisions.size() != 0 || cmd_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int in_pct, input int out_pct);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        add_random_divisions(count);
        wait_drained();
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_data  <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_results.push_back(predict_division(cmd_data));
                sent_count++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_divisions.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data  <= pending_divisions.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        div_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer %h", $time, res_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (want.divide_error)
                    fault_count++;
                if (res_data.quotient !== want.quotient)
                begin
                    $display("%0t: quotient mismatch, expected %h, actual %h",
                             $time, want.quotient, res_data.quotient);
                    error_count++;
                end
                if (res_data.remainder !== want.remainder)
                begin
                    $display("%0t: remainder mismatch, expected %h, actual %h",
                             $time, want.remainder, res_data.remainder);
                    error_count++;
                end
                if (res_data.divide_error !== want.divide_error)
                begin
                    $display("%0t: divide_error mismatch, expected %b, actual %b",
                             $time, want.divide_error, res_data.divide_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)
            || (pending_divisions.size() == 0 && !cmd_valid && expected_results.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 8-bit unsigned: overflow, limits, zero divisor in low byte only
        add_division(CMD_DIV8,   16'hffff, 16'hffff, 16'h00ff);
        add_division(CMD_DIV8,   16'h0000, 16'hfe01, 16'hffff);
        add_division(CMD_DIV8,   16'h1234, 16'hff00, 16'h00ff);
        add_division(CMD_DIV8,   16'h0000, 16'h00ff, 16'h0001);
        add_division(CMD_DIV8,   16'hffff, 16'h1234, 16'hff00);
        // 16-bit unsigned
        add_division(CMD_DIV16,  16'hffff, 16'hffff, 16'hffff);
        add_division(CMD_DIV16,  16'hfffe, 16'h0001, 16'hffff);
        add_division(CMD_DIV16,  16'h0000, 16'h0000, 16'h0000);
        add_division(CMD_DIV16,  16'h0000, 16'hffff, 16'h0001);
        // 8-bit signed: most negative by minus one, quotient of -128, truncation
        add_division(CMD_IDIV8,  16'h0000, 16'h8000, 16'h00ff);
        add_division(CMD_IDIV8,  16'h0000, 16'hff80, 16'h0001);
        add_division(CMD_IDIV8,  16'h0000, 16'h0080, 16'hffff);
        add_division(CMD_IDIV8,  16'h0000, 16'h007f, 16'h0001);
        add_division(CMD_IDIV8,  16'h0000, 16'h0080, 16'h0001);
        add_division(CMD_IDIV8,  16'hffff, 16'hfff9, 16'h0002);
        add_division(CMD_IDIV8,  16'h0000, 16'h0007, 16'h00fe);
        add_division(CMD_IDIV8,  16'h0000, 16'h1234, 16'hff00);
        // 16-bit signed
        add_division(CMD_IDIV16, 16'h8000, 16'h0000, 16'hffff);
        add_division(CMD_IDIV16, 16'hffff, 16'h8000, 16'h0001);
        add_division(CMD_IDIV16, 16'h0000, 16'h8000, 16'hffff);
        add_division(CMD_IDIV16, 16'h0000, 16'h8000, 16'h0001);
        add_division(CMD_IDIV16, 16'h0000, 16'h7fff, 16'h0001);
        add_division(CMD_IDIV16, 16'hffff, 16'hfff9, 16'h0002);
        add_division(CMD_IDIV16, 16'h7fff, 16'hffff, 16'h0000);
        wait_drained();

        run_phase(300, 0, 0);
        run_phase(250, 77, 0);
        run_phase(250, 0, 77);
        run_phase(250, 21, 21);

        // long result-side hold while the sender keeps offering, fills every stage
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_requests++;
        add_random_divisions(100);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d divisions sent, %0d results checked, %0d of them divide errors",
                 sent_count, checked_count, fault_count);
        $display("all four opcodes under idle, stall, mixed and full back-pressure phases");
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
